>>> hdl/btmx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btmx_pkg
// Shared constants and types for the binary trie maximum-XOR block.
// ----------------------------------------------------------------------------
package btmx_pkg;

    localparam int VALUE_BITS = 60;
    localparam int NODE_COUNT = 65536;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int FREE_W     = NODE_W + 1;
    localparam int LEVEL_W    = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int LINK_W     = 2 * NODE_W;

    // highest free pointer that still leaves a full path of nodes
    localparam logic [FREE_W-1:0] FREE_LIMIT = FREE_W'(NODE_COUNT - VALUE_BITS);
    localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(VALUE_BITS - 1);

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [NODE_W-1:0]     t_node;

    typedef struct packed {
        t_node zero;
        t_node one;
    } t_links;

    typedef struct packed {
        logic load;
        logic shift_v;
        logic shift_a;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_QUERY,
        S_INSERT,
        S_DONE
    } t_state;

endpackage

>>> hdl/btmx_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btmx_cell
// One bit slice of the walk chain: holds a value bit and a result bit.
// ----------------------------------------------------------------------------
module btmx_cell (
    input  logic                 i_clk,
    input  btmx_pkg::t_cell_ctrl i_ctrl,
    input  logic                 i_load_v,
    input  logic                 i_v_in,
    input  logic                 i_a_in,
    output logic                 o_v,
    output logic                 o_a
);
    import btmx_pkg::*;

    logic r_v, n_v;
    logic r_a, n_a;

    always_comb begin
        n_v = r_v;
        n_a = r_a;
        if (i_ctrl.load) begin
            n_v = i_load_v;
            n_a = 1'b0;
        end else begin
            if (i_ctrl.shift_v) begin
                n_v = i_v_in;
            end
            if (i_ctrl.shift_a) begin
                n_a = i_a_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
        r_a <= n_a;
    end

    assign o_v = r_v;
    assign o_a = r_a;

endmodule

>>> hdl/binary_trie_max_xor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_trie_max_xor
// Streaming maximum-XOR search and insert over a binary trie in node memory.
// ----------------------------------------------------------------------------
// Each transfer on the input carries one value. The block first walks the
// trie from the top bit down, one level per cycle, taking the branch opposite
// to the value's bit where it exists, then walks again to insert the value,
// allocating new nodes from a free pointer. Each value is both queried and
// inserted, but one walk is skipped when there is nothing to do: no query
// while nothing is stored yet, no insert once the store is full. A stalled
// output holds the block in its done state. The walk rate is set by the
// single node memory port, which serves one trie level per cycle with a
// registered read. The value and the XOR result travel through a rotating
// row of bit cells, so the top cell always presents the bit of the current
// level. Once fewer than VALUE_BITS nodes remain free, values are no longer
// inserted and store_full is set. Results sit in an output register, so a
// new value is accepted while the previous result waits. The root links
// are flip-flops cleared by reset; all other nodes are written when
// allocated, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module binary_trie_max_xor (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [59:0]              i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [59:0]              o_best_with_earlier,
    output logic                     o_had_earlier,
    output logic [59:0]              o_best_pair_xor,
    output logic [59:0]              o_largest_value,
    output logic [59:0]              o_xor_of_all,
    output logic                     o_store_full
);
    import btmx_pkg::*;

    // control state
    t_state             r_state, n_state;
    logic [LEVEL_W-1:0] r_level, n_level;
    t_node              r_node, n_node;
    logic [FREE_W-1:0]  r_free, n_free;
    logic               r_fresh, n_fresh;   // below a new node: links known empty
    logic               r_dead, n_dead;     // query ran out of branches
    logic               r_nonzero, n_nonzero;
    logic               r_had, n_had;
    logic               r_full, n_full;
    logic               r_out_valid, n_out_valid;
    t_links             r_root, n_root;

    // running results
    t_value r_pair, n_pair;
    t_value r_max, n_max;
    t_value r_xor, n_xor;
    t_value r_out_best, n_out_best;
    logic   r_out_had, n_out_had;
    logic   r_out_full, n_out_full;

    // node memory (node 0 lives in r_root)
    t_links r_mem [NODE_COUNT];
    t_links r_rd_data;
    logic   mem_we;
    t_links mem_wdata;

    // bit cell row
    t_cell_ctrl cell_ctrl;
    logic       a_in;
    t_value     cell_v, cell_a;

    t_links cur;
    logic   bit_cur;
    t_node  other_link, same_link;
    t_value value_in;

    assign value_in = i_value;
    assign bit_cur  = cell_v[VALUE_BITS-1];

    genvar gi;
    generate
        for (gi = 0; gi < VALUE_BITS; gi++) begin : g_cell
            btmx_cell u_cell (
                .i_clk    (i_clk),
                .i_ctrl   (cell_ctrl),
                .i_load_v (value_in[gi]),
                .i_v_in   ((gi == 0) ? cell_v[VALUE_BITS-1] : cell_v[(gi == 0) ? 0 : gi-1]),
                .i_a_in   ((gi == 0) ? a_in : cell_a[(gi == 0) ? 0 : gi-1]),
                .o_v      (cell_v[gi]),
                .o_a      (cell_a[gi])
            );
        end
    endgenerate

    // links of the current node
    always_comb begin
        if (r_fresh) begin
            cur = '0;
        end else if (r_node == '0) begin
            cur = r_root;
        end else begin
            cur = r_rd_data;
        end
        other_link = bit_cur ? cur.zero : cur.one;
        same_link  = bit_cur ? cur.one  : cur.zero;
    end

    always_comb begin
        n_state     = r_state;
        n_level     = r_level;
        n_node      = r_node;
        n_free      = r_free;
        n_fresh     = r_fresh;
        n_dead      = r_dead;
        n_nonzero   = r_nonzero;
        n_had       = r_had;
        n_full      = r_full;
        n_out_valid = r_out_valid;
        n_root      = r_root;
        n_pair      = r_pair;
        n_max       = r_max;
        n_xor       = r_xor;
        n_out_best  = r_out_best;
        n_out_had   = r_out_had;
        n_out_full  = r_out_full;
        cell_ctrl   = '0;
        a_in        = 1'b0;
        mem_we      = 1'b0;
        mem_wdata   = cur;
        o_in_stall  = 1'b1;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    cell_ctrl.load = 1'b1;
                    n_level = TOP_LEVEL;
                    n_node  = '0;
                    n_fresh = 1'b0;
                    n_dead  = 1'b0;
                    n_had   = r_nonzero;
                    n_full  = (r_free > FREE_LIMIT);
                    if (r_nonzero) begin
                        n_state = S_QUERY;
                    end else if (r_free > FREE_LIMIT) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_INSERT;
                    end
                end
            end
            S_QUERY: begin
                cell_ctrl.shift_v = 1'b1;
                cell_ctrl.shift_a = 1'b1;
                if (r_dead) begin
                    a_in = 1'b0;
                end else if (other_link != '0) begin
                    a_in   = 1'b1;
                    n_node = other_link;
                end else if (same_link != '0) begin
                    n_node = same_link;
                end else begin
                    n_dead = 1'b1;
                end
                n_level = r_level - 1'b1;
                if (r_level == '0) begin
                    n_level = TOP_LEVEL;
                    n_node  = '0;
                    n_dead  = 1'b0;
                    n_state = r_full ? S_DONE : S_INSERT;
                end
            end
            S_INSERT: begin
                cell_ctrl.shift_v = 1'b1;
                if (same_link != '0 && !r_fresh) begin
                    n_node = same_link;
                end else begin
                    if (bit_cur) begin
                        mem_wdata.one = r_free[NODE_W-1:0];
                    end else begin
                        mem_wdata.zero = r_free[NODE_W-1:0];
                    end
                    if (r_node == '0) begin
                        n_root = mem_wdata;
                    end else begin
                        mem_we = 1'b1;
                    end
                    n_node  = r_free[NODE_W-1:0];
                    n_free  = r_free + 1'b1;
                    n_fresh = 1'b1;
                end
                n_level = r_level - 1'b1;
                if (r_level == '0) begin
                    n_nonzero = 1'b1;
                    n_fresh   = 1'b0;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_best  = cell_a;
                    n_out_had   = r_had;
                    n_out_full  = r_full;
                    if (r_had && (cell_a > r_pair)) begin
                        n_pair = cell_a;
                    end
                    if (cell_v > r_max) begin
                        n_max = cell_v;
                    end
                    n_xor   = r_xor ^ cell_v;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_node      <= '0;
            r_free      <= FREE_W'(1);
            r_fresh     <= 1'b0;
            r_dead      <= 1'b0;
            r_nonzero   <= 1'b0;
            r_had       <= 1'b0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
            r_root      <= '0;
            r_pair      <= '0;
            r_max       <= '0;
            r_xor       <= '0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_node      <= n_node;
            r_free      <= n_free;
            r_fresh     <= n_fresh;
            r_dead      <= n_dead;
            r_nonzero   <= n_nonzero;
            r_had       <= n_had;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
            r_root      <= n_root;
            r_pair      <= n_pair;
            r_max       <= n_max;
            r_xor       <= n_xor;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_best <= n_out_best;
        r_out_had  <= n_out_had;
        r_out_full <= n_out_full;
    end

    // node memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_node] <= mem_wdata;
        end
        r_rd_data <= r_mem[n_node];
    end

    assign o_out_valid         = r_out_valid;
    assign o_best_with_earlier = r_out_best;
    assign o_had_earlier       = r_out_had;
    assign o_best_pair_xor     = r_pair;
    assign o_largest_value     = r_max;
    assign o_xor_of_all        = r_xor;
    assign o_store_full        = r_out_full;

endmodule
